### src/assert_macros.svh
// Assertion macros used by the clustering unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Whenever the condition holds, the consequence holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

`endif

### src/dpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dpc_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_BITS = 16;
   localparam int PT_AW      = $clog2(MAX_POINTS);
   localparam int CNT_W      = PT_AW + 1;
   localparam int PT_W       = 3 * COORD_BITS;
   localparam int EPS_W      = 36;
   localparam int MINPTS_W   = 11;
   localparam int CMP_W      = (CNT_W > MINPTS_W) ? CNT_W : MINPTS_W;
   localparam int SQ_W       = 2 * COORD_BITS + 2;
   localparam int DIST_W     = (SQ_W > EPS_W) ? SQ_W : EPS_W;

   localparam logic REG_EPS    = 1'b0;
   localparam logic REG_MINPTS = 1'b1;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_RUN   = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic {
      SCAN_COUNT = 1'b0,
      SCAN_ENQ   = 1'b1
   } scan_mode_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLR,
      ST_OUTER,
      ST_OCHK,
      ST_OCORE,
      ST_QCLR,
      ST_DEQ,
      ST_DQ1,
      ST_DQ2,
      ST_DQCORE,
      ST_SCAN_A,
      ST_SCAN_B,
      ST_SCAN_W,
      ST_FIN,
      ST_RDLBL,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

### src/dpc_dist.sv
`timescale 1ns / 1ps
`default_nettype none
module dpc_dist import dpc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [PT_W-1:0]  pt_a,
   input  wire logic [PT_W-1:0]  pt_b,
   input  wire logic [EPS_W-1:0] eps,
   output logic                  done,
   output logic                  near
);

   logic                  busy_ff, busy_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic [PT_W-1:0]       b_ff, b_in;
   logic [SQ_W-1:0]       prod_ff, prod_in;
   logic [SQ_W-1:0]       acc_ff, acc_in;
   logic [COORD_BITS-1:0] a_k, b_k;
   logic signed [COORD_BITS:0] diff;
   logic signed [SQ_W-1:0] sq;

   always_comb begin
      unique case (cnt_ff)
         3'd0: begin
            a_k = pt_a[COORD_BITS-1:0];
            b_k = b_ff[COORD_BITS-1:0];
         end
         3'd1: begin
            a_k = pt_a[2*COORD_BITS-1:COORD_BITS];
            b_k = b_ff[2*COORD_BITS-1:COORD_BITS];
         end
         default: begin
            a_k = pt_a[3*COORD_BITS-1:2*COORD_BITS];
            b_k = b_ff[3*COORD_BITS-1:2*COORD_BITS];
         end
      endcase
      diff = $signed({a_k[COORD_BITS-1], a_k}) - $signed({b_k[COORD_BITS-1], b_k});
      sq   = SQ_W'(diff) * SQ_W'(diff);
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         b_in    = pt_b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff <= 3'd2) begin
            prod_in = $unsigned(sq);
         end
         if (cnt_ff >= 3'd1 && cnt_ff <= 3'd3) begin
            acc_in = acc_ff + prod_ff;
         end
         if (cnt_ff == 3'd4) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   assign done = busy_ff && (cnt_ff == 3'd4);
   assign near = DIST_W'(acc_ff) <= DIST_W'(eps);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule
`default_nettype wire

### src/density_point_clustering_unit.sv
// Density clustering of stored 3-D points.
// The req channel carries one command per word: clear, load a point, run the
// clustering, or read the label of one point. Every command gives exactly one
// word on the rsp channel, which always shows the summary of the last run.
// The csr port writes eps_squared (index 0) and min_points (index 1), and writes
// take effect at once. The user must write them only while the block is idle;
// the block itself does not enforce this. A run first sweeps the loaded points
// (one per cycle), then visits them; every neighborhood scan tests all loaded
// points through one shared squared-distance unit, and each point is scanned at
// most twice; each cluster adds one more sweep of the loaded points.
// Only one command is in work at a time.
// The result sits in an output register; the next command is taken as soon as
// that word is taken or in the same cycle. When rsp_tready stays low the block
// holds its result and accepts nothing more.
// Synchronous reset empties the point store, zeroes the run summary and both
// configuration registers, and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module density_point_clustering_unit import dpc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // x_coord[15:0], y_coord[31:16], z_coord[47:32], point_index[57:48]
   input  wire logic [63:0] req_tdata,
   // command[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // cluster_count[10:0], biggest_cluster[20:11], biggest_size[31:21],
   // no_cluster[32], point_label[43:33], noise_mark[44], store_full[45]
   output logic [47:0]      rsp_tdata,
   input  wire logic        csr_wen,
   input  wire logic        csr_index,
   input  wire logic [35:0] csr_wdata
);

   state_type          state_ff, state_in, ret_ff, ret_in;
   scan_mode_type      mode_ff, mode_in;
   logic [CNT_W-1:0]   count_ff, count_in, cnt_ff, cnt_in, i_ff, i_in, n_ff, n_in;
   logic [CNT_W-1:0]   head_ff, head_in, tail_ff, tail_in, clus_ff, clus_in;
   logic [CNT_W-1:0]   csize_ff, csize_in, bigsz_ff, bigsz_in, clus_dec;
   logic [PT_AW-1:0]   big_ff, big_in, q_ff, q_in;
   logic [PT_W-1:0]    p_ff, p_in;
   logic [EPS_W-1:0]   eps_ff;
   logic [MINPTS_W-1:0] minpts_ff;
   logic [10:0]        sum_count_ff, sum_count_in, sum_size_ff, sum_size_in;
   logic [9:0]         sum_big_ff, sum_big_in;
   logic               sum_none_ff, sum_none_in;
   logic [10:0]        res_label_ff, res_label_in;
   logic               res_noise_ff, res_noise_in, res_full_ff, res_full_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [PT_W-1:0]    pt_mem [MAX_POINTS];
   logic [CNT_W-1:0]   lbl_mem [MAX_POINTS];
   logic               nz_mem [MAX_POINTS];
   logic               vis_mem [MAX_POINTS];
   logic               qf_mem [MAX_POINTS];
   logic [PT_AW-1:0]   seed_mem [MAX_POINTS];

   logic               pt_we, lbl_we, nz_we, vis_we, qf_we, seed_we;
   logic [PT_AW-1:0]   pt_waddr, lbl_waddr, nz_waddr, vis_waddr, qf_waddr, seed_waddr;
   logic [PT_AW-1:0]   pt_raddr, lbl_raddr, nz_raddr, vis_raddr, qf_raddr, seed_raddr;
   logic [PT_W-1:0]    pt_wdata, pt_rd_ff;
   logic [CNT_W-1:0]   lbl_wdata, lbl_rd_ff;
   logic               nz_wdata, vis_wdata, qf_wdata;
   logic               nz_rd_ff, vis_rd_ff, qf_rd_ff;
   logic [PT_AW-1:0]   seed_wdata, seed_rd_ff;

   logic               req_fire, hood_low, idx_ok, full_now, dist_start, dist_done, dist_near;
   cmd_type            req_cmd;
   logic [9:0]         req_idx;

   assign req_fire = req_tvalid && req_tready;
   assign req_cmd  = cmd_type'(req_tuser);
   assign req_idx  = req_tdata[57:48];
   assign idx_ok   = CMP_W'(req_idx) < CMP_W'(count_ff);
   assign full_now = count_ff == CNT_W'(MAX_POINTS);
   assign hood_low = CMP_W'(n_ff) < CMP_W'(minpts_ff);
   assign clus_dec = clus_ff - CNT_W'(1);
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);

   dpc_dist u_dist (
      .clock (clock),
      .reset (reset),
      .start (dist_start),
      .pt_a  (p_ff),
      .pt_b  (pt_rd_ff),
      .eps   (eps_ff),
      .done  (dist_done),
      .near  (dist_near)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_cmd)
                  CMD_CLEAR, CMD_LOAD: state_in = ST_DONE;
                  CMD_RUN:             state_in = ST_CLR;
                  CMD_READ:            state_in = idx_ok ? ST_RDLBL : ST_DONE;
               endcase
            end
         end
         ST_CLR:    if (cnt_ff == count_ff) state_in = ST_OUTER;
         ST_OUTER:  state_in = (i_ff == count_ff) ? ST_FIN : ST_OCHK;
         ST_OCHK:   state_in = vis_rd_ff ? ST_OUTER : ST_SCAN_A;
         ST_OCORE:  state_in = hood_low ? ST_OUTER : ST_QCLR;
         ST_QCLR:   if (cnt_ff == count_ff) state_in = ST_SCAN_A;
         ST_SCAN_A: state_in = (cnt_ff == count_ff) ? ret_ff : ST_SCAN_B;
         ST_SCAN_B: state_in = ST_SCAN_W;
         ST_SCAN_W: if (dist_done) state_in = ST_SCAN_A;
         ST_DEQ:    state_in = (head_ff == tail_ff) ? ST_OUTER : ST_DQ1;
         ST_DQ1:    state_in = ST_DQ2;
         ST_DQ2:    state_in = vis_rd_ff ? ST_DEQ : ST_SCAN_A;
         ST_DQCORE: state_in = hood_low ? ST_DEQ : ST_SCAN_A;
         ST_FIN:    state_in = ST_DONE;
         ST_RDLBL:  state_in = ST_DONE;
         ST_DONE:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ret_in       = ret_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      n_in         = n_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      clus_in      = clus_ff;
      csize_in     = csize_ff;
      bigsz_in     = bigsz_ff;
      big_in       = big_ff;
      q_in         = q_ff;
      p_in         = p_ff;
      sum_count_in = sum_count_ff;
      sum_big_in   = sum_big_ff;
      sum_size_in  = sum_size_ff;
      sum_none_in  = sum_none_ff;
      res_label_in = res_label_ff;
      res_noise_in = res_noise_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      dist_start   = 1'b0;
      pt_we = 1'b0;  pt_waddr = cnt_ff[PT_AW-1:0];  pt_wdata = '0;
      lbl_we = 1'b0; lbl_waddr = cnt_ff[PT_AW-1:0]; lbl_wdata = '0;
      nz_we = 1'b0;  nz_waddr = cnt_ff[PT_AW-1:0];  nz_wdata = 1'b0;
      vis_we = 1'b0; vis_waddr = cnt_ff[PT_AW-1:0]; vis_wdata = 1'b0;
      qf_we = 1'b0;  qf_waddr = cnt_ff[PT_AW-1:0];  qf_wdata = 1'b0;
      seed_we = 1'b0; seed_waddr = tail_ff[PT_AW-1:0]; seed_wdata = cnt_ff[PT_AW-1:0];
      pt_raddr   = cnt_ff[PT_AW-1:0];
      lbl_raddr  = PT_AW'(req_idx);
      nz_raddr   = PT_AW'(req_idx);
      vis_raddr  = i_ff[PT_AW-1:0];
      qf_raddr   = cnt_ff[PT_AW-1:0];
      seed_raddr = head_ff[PT_AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_label_in = '0;
               res_noise_in = 1'b0;
               res_full_in  = 1'b0;
               unique case (req_cmd)
                  CMD_CLEAR: count_in = '0;
                  CMD_LOAD: begin
                     if (full_now) begin
                        res_full_in = 1'b1;
                     end else begin
                        pt_we     = 1'b1;
                        pt_waddr  = count_ff[PT_AW-1:0];
                        pt_wdata  = {COORD_BITS'(req_tdata[47:32]),
                                     COORD_BITS'(req_tdata[31:16]),
                                     COORD_BITS'(req_tdata[15:0])};
                        lbl_we    = 1'b1;
                        lbl_waddr = count_ff[PT_AW-1:0];
                        nz_we     = 1'b1;
                        nz_waddr  = count_ff[PT_AW-1:0];
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_RUN: begin
                     cnt_in   = '0;
                     clus_in  = '0;
                     big_in   = '0;
                     bigsz_in = '0;
                  end
                  CMD_READ: begin
                  end
               endcase
            end
         end
         ST_CLR: begin
            if (cnt_ff != count_ff) begin
               lbl_we = 1'b1;
               nz_we  = 1'b1;
               vis_we = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               i_in = '0;
            end
         end
         ST_OUTER: begin
            pt_raddr = i_ff[PT_AW-1:0];
         end
         ST_OCHK: begin
            if (vis_rd_ff) begin
               i_in = i_ff + CNT_W'(1);
            end else begin
               vis_we    = 1'b1;
               vis_waddr = i_ff[PT_AW-1:0];
               vis_wdata = 1'b1;
               p_in      = pt_rd_ff;
               cnt_in    = '0;
               n_in      = '0;
               mode_in   = SCAN_COUNT;
               ret_in    = ST_OCORE;
            end
         end
         ST_OCORE: begin
            if (hood_low) begin
               nz_we    = 1'b1;
               nz_waddr = i_ff[PT_AW-1:0];
               nz_wdata = 1'b1;
               i_in     = i_ff + CNT_W'(1);
            end else begin
               clus_in   = clus_ff + CNT_W'(1);
               lbl_we    = 1'b1;
               lbl_waddr = i_ff[PT_AW-1:0];
               lbl_wdata = clus_ff + CNT_W'(1);
               csize_in  = CNT_W'(1);
               cnt_in    = '0;
            end
         end
         ST_QCLR: begin
            if (cnt_ff != count_ff) begin
               qf_we  = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               cnt_in  = '0;
               head_in = '0;
               tail_in = '0;
               mode_in = SCAN_ENQ;
               ret_in  = ST_DEQ;
            end
         end
         ST_SCAN_A: begin
         end
         ST_SCAN_B: begin
            dist_start = 1'b1;
         end
         ST_SCAN_W: begin
            if (dist_done) begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (dist_near) begin
                  if (mode_ff == SCAN_COUNT) begin
                     n_in = n_ff + CNT_W'(1);
                  end else if (!qf_rd_ff) begin
                     qf_we    = 1'b1;
                     qf_wdata = 1'b1;
                     seed_we  = 1'b1;
                     tail_in  = tail_ff + CNT_W'(1);
                  end
               end
            end
         end
         ST_DEQ: begin
            if (head_ff == tail_ff) begin
               if (csize_ff > bigsz_ff) begin
                  bigsz_in = csize_ff;
                  big_in   = clus_dec[PT_AW-1:0];
               end
               i_in = i_ff + CNT_W'(1);
            end else begin
               head_in = head_ff + CNT_W'(1);
            end
         end
         ST_DQ1: begin
            q_in      = seed_rd_ff;
            vis_raddr = seed_rd_ff;
            lbl_raddr = seed_rd_ff;
            pt_raddr  = seed_rd_ff;
         end
         ST_DQ2: begin
            if (lbl_rd_ff == '0) begin
               lbl_we    = 1'b1;
               lbl_waddr = q_ff;
               lbl_wdata = clus_ff;
               csize_in  = csize_ff + CNT_W'(1);
            end
            if (!vis_rd_ff) begin
               vis_we    = 1'b1;
               vis_waddr = q_ff;
               vis_wdata = 1'b1;
               p_in      = pt_rd_ff;
               cnt_in    = '0;
               n_in      = '0;
               mode_in   = SCAN_COUNT;
               ret_in    = ST_DQCORE;
            end
         end
         ST_DQCORE: begin
            cnt_in  = '0;
            mode_in = SCAN_ENQ;
            ret_in  = ST_DEQ;
         end
         ST_FIN: begin
            sum_count_in = 11'(clus_ff);
            sum_big_in   = 10'(big_ff);
            sum_size_in  = 11'(bigsz_ff);
            sum_none_in  = clus_ff == '0;
         end
         ST_RDLBL: begin
            res_label_in = 11'(lbl_rd_ff);
            res_noise_in = nz_rd_ff;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, res_full_ff, res_noise_ff, res_label_ff, sum_none_ff,
                        sum_size_ff, sum_big_ff, sum_count_ff};

   always_ff @(posedge clock) begin
      if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
      pt_rd_ff <= pt_mem[pt_raddr];
   end

   always_ff @(posedge clock) begin
      if (lbl_we) lbl_mem[lbl_waddr] <= lbl_wdata;
      lbl_rd_ff <= lbl_mem[lbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (nz_we) nz_mem[nz_waddr] <= nz_wdata;
      nz_rd_ff <= nz_mem[nz_raddr];
   end

   always_ff @(posedge clock) begin
      if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
      vis_rd_ff <= vis_mem[vis_raddr];
   end

   always_ff @(posedge clock) begin
      if (qf_we) qf_mem[qf_waddr] <= qf_wdata;
      qf_rd_ff <= qf_mem[qf_raddr];
   end

   always_ff @(posedge clock) begin
      if (seed_we) seed_mem[seed_waddr] <= seed_wdata;
      seed_rd_ff <= seed_mem[seed_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         mode_ff      <= SCAN_COUNT;
         count_ff     <= '0;
         cnt_ff       <= '0;
         i_ff         <= '0;
         n_ff         <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         clus_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         eps_ff       <= '0;
         minpts_ff    <= '0;
         sum_count_ff <= '0;
         sum_big_ff   <= '0;
         sum_size_ff  <= '0;
         sum_none_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         cnt_ff       <= cnt_in;
         i_ff         <= i_in;
         n_ff         <= n_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         clus_ff      <= clus_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_count_ff <= sum_count_in;
         sum_big_ff   <= sum_big_in;
         sum_size_ff  <= sum_size_in;
         sum_none_ff  <= sum_none_in;
         if (csr_wen) begin
            if (csr_index == REG_MINPTS) begin
               minpts_ff <= csr_wdata[MINPTS_W-1:0];
            end else begin
               eps_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      csize_ff     <= csize_in;
      bigsz_ff     <= bigsz_in;
      big_ff       <= big_in;
      q_ff         <= q_in;
      p_ff         <= p_in;
      res_label_ff <= res_label_in;
      res_noise_ff <= res_noise_in;
      res_full_ff  <= res_full_in;
   end

   `ASSERT_ALWAYS(a_count_max, clock, reset, count_ff <= CNT_W'(MAX_POINTS))
   `ASSERT_ALWAYS(a_queue_order, clock, reset, head_ff <= tail_ff)
   `ASSERT_IMPLIES(a_queue_bound, clock, reset, state_ff == ST_DEQ, tail_ff <= count_ff)
   `ASSERT_IMPLIES(a_dist_in_scan, clock, reset, dist_done, state_ff == ST_SCAN_W)

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import dpc_pkg::*;

   localparam int STALL_LIMIT = 400000;

   typedef struct {
      cmd_type     cmd;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
      logic [9:0]  idx;
   } command_word_type;

   typedef struct {
      logic [10:0] count;
      logic [9:0]  big;
      logic [10:0] size;
      logic        none;
      logic [10:0] label;
      logic        noise;
      logic        full;
   } status_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        csr_wen;
   logic        csr_index;
   logic [35:0] csr_wdata;

   density_point_clustering_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   command_word_type pending_cmds[$];
   status_word_type  expected_status[$];
   command_word_type held_cmd;
   bit            quiet;
   int            req_gap;
   int            rsp_gap;
   int            mismatches;
   int            stall_cycles;

   // Shadow copy of the clustering state.
   logic [35:0]   eps_sq;
   logic [10:0]   min_pts;
   int            px[MAX_POINTS];
   int            py[MAX_POINTS];
   int            pz[MAX_POINTS];
   int            n_points;
   int            labels[MAX_POINTS];
   bit            noise_seen[MAX_POINTS];
   bit            visited[MAX_POINTS];
   bit            queued[MAX_POINTS];
   int            seeds[MAX_POINTS];
   int            csizes[MAX_POINTS];
   int            last_count, last_big, last_size, last_none;

   function automatic bit is_near(int a, int b);
      longint d, acc;
      acc = 0;
      d = longint'(px[a]) - longint'(px[b]);
      acc += d * d;
      d = longint'(py[a]) - longint'(py[b]);
      acc += d * d;
      d = longint'(pz[a]) - longint'(pz[b]);
      acc += d * d;
      return acc <= longint'({28'd0, eps_sq});
   endfunction

   function automatic int hood_count(int p);
      int n;
      n = 0;
      for (int j = 0; j < n_points; j++) if (is_near(p, j)) n++;
      return n;
   endfunction

   function automatic void queue_hood(int p, ref int tail);
      for (int j = 0; j < n_points; j++) begin
         if (!queued[j] && is_near(p, j) && tail < MAX_POINTS) begin
            queued[j] = 1;
            seeds[tail] = j;
            tail++;
         end
      end
   endfunction

   function automatic void cluster_points();
      int clusters, big, bigsz, head, tail, tag, q, c;
      clusters = 0;
      big = 0;
      bigsz = 0;
      for (int i = 0; i < MAX_POINTS; i++) begin
         labels[i] = 0;
         noise_seen[i] = 0;
         visited[i] = 0;
      end
      for (int i = 0; i < n_points; i++) begin
         if (visited[i]) continue;
         visited[i] = 1;
         if (hood_count(i) < min_pts) begin
            noise_seen[i] = 1;
            continue;
         end
         c = clusters++;
         tag = c + 1;
         for (int j = 0; j < MAX_POINTS; j++) queued[j] = 0;
         labels[i] = tag;
         csizes[c] = 1;
         head = 0;
         tail = 0;
         queue_hood(i, tail);
         while (head < tail) begin
            q = seeds[head++];
            if (!visited[q]) begin
               visited[q] = 1;
               if (hood_count(q) >= min_pts) queue_hood(q, tail);
            end
            if (labels[q] == 0) begin
               labels[q] = tag;
               csizes[c]++;
            end
         end
      end
      for (int k = 0; k < clusters; k++) begin
         if (csizes[k] > bigsz) begin
            bigsz = csizes[k];
            big = k;
         end
      end
      last_count = clusters;
      last_big = big;
      last_size = bigsz;
      last_none = (clusters == 0);
   endfunction

   function automatic status_word_type apply_command(command_word_type w);
      status_word_type r;
      r.label = 0;
      r.noise = 0;
      r.full = 0;
      case (w.cmd)
         CMD_CLEAR: begin
            n_points = 0;
            for (int i = 0; i < MAX_POINTS; i++) begin
               labels[i] = 0;
               noise_seen[i] = 0;
            end
         end
         CMD_LOAD: begin
            if (n_points >= MAX_POINTS) begin
               r.full = 1;
            end else begin
               px[n_points] = int'($signed(w.x));
               py[n_points] = int'($signed(w.y));
               pz[n_points] = int'($signed(w.z));
               labels[n_points] = 0;
               noise_seen[n_points] = 0;
               n_points++;
            end
         end
         CMD_RUN: cluster_points();
         default: begin
            if (int'(w.idx) < n_points) begin
               r.label = 11'(labels[w.idx]);
               r.noise = noise_seen[w.idx];
            end
         end
      endcase
      r.count = 11'(last_count);
      r.big = 10'(last_big);
      r.size = 11'(last_size);
      r.none = 1'(last_none);
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= 0;
         req_tuser <= CMD_CLEAR;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_status = {expected_status, apply_command(held_cmd)};
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               req_gap = $urandom_range(1, 12);
               req_tvalid <= 0;
            end else if (pending_cmds.size() > 0) begin
               held_cmd = pending_cmds.pop_front();
               req_tdata <= {6'd0, held_cmd.idx, held_cmd.z, held_cmd.y, held_cmd.x};
               req_tuser <= held_cmd.cmd;
               req_tvalid <= 1;
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         rsp_gap = 0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_gap = $urandom_range(1, 12);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      status_word_type exp_w, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.count = rsp_tdata[10:0];
         got.big = rsp_tdata[20:11];
         got.size = rsp_tdata[31:21];
         got.none = rsp_tdata[32];
         got.label = rsp_tdata[43:33];
         got.noise = rsp_tdata[44];
         got.full = rsp_tdata[45];
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected word %h", rsp_tdata);
         end else begin
            exp_w = expected_status.pop_front();
            if (exp_w.count !== got.count || exp_w.big !== got.big
                  || exp_w.size !== got.size || exp_w.none !== got.none
                  || exp_w.label !== got.label || exp_w.noise !== got.noise
                  || exp_w.full !== got.full) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Mismatch: expected count %0d big %0d size %0d none %0d ",
                            "label %0d noise %0d full %0d, got %0d %0d %0d %0d %0d %0d %0d"},
                           exp_w.count, exp_w.big, exp_w.size, exp_w.none, exp_w.label,
                           exp_w.noise, exp_w.full, got.count, got.big, got.size, got.none,
                           got.label, got.noise, got.full);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send(cmd_type c, logic [15:0] x = 0, logic [15:0] y = 0,
                       logic [15:0] z = 0, logic [9:0] idx = 0);
      command_word_type w;
      w.cmd = c;
      w.x = x;
      w.y = y;
      w.z = z;
      w.idx = idx;
      pending_cmds = {pending_cmds, w};
   endtask

   task automatic send_random();
      send(cmd_type'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 16'($urandom),
           10'($urandom_range(0, 1023)));
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_tvalid || expected_status.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(bit index, logic [35:0] value);
      @(posedge clock);
      csr_wen <= 1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == REG_EPS) eps_sq = value;
      else min_pts = value[10:0];
      @(posedge clock);
      csr_wen <= 0;
   endtask

   task automatic load_blob(int n, int spread);
      int cx, cy, cz;
      cx = $urandom_range(0, 60000) - 30000;
      cy = $urandom_range(0, 60000) - 30000;
      cz = $urandom_range(0, 60000) - 30000;
      for (int i = 0; i < n; i++)
         send(CMD_LOAD, 16'(cx + $urandom_range(0, spread)), 16'(cy + $urandom_range(0, spread)),
              16'(cz + $urandom_range(0, spread)));
   endtask

   initial begin
      int random_items, n, sel;
      logic [35:0] eps_choice;
      reset = 1;
      quiet = 0;
      csr_wen = 0;
      csr_index = 0;
      csr_wdata = 0;
      eps_sq = 0;
      min_pts = 0;
      n_points = 0;
      last_count = 0;
      last_big = 0;
      last_size = 0;
      last_none = 0;
      mismatches = 0;
      for (int i = 0; i < MAX_POINTS; i++) begin
         labels[i] = 0;
         noise_seen[i] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 0;

      send(CMD_READ, 0, 0, 0, 0);
      send(CMD_RUN);
      send(CMD_LOAD, 16'h8000, 16'h8000, 16'h8000);
      send(CMD_LOAD, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send(CMD_LOAD, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send(CMD_LOAD, 16'hFFFF, 16'h0000, 16'h0001);
      send(CMD_RUN);
      for (int i = 0; i < 4; i++) send(CMD_READ, 0, 0, 0, 10'(i));
      send(CMD_READ, 0, 0, 0, 10'h3FF);
      wait_idle();
      write_csr(REG_EPS, 36'hFFFFFFFFF);
      write_csr(REG_MINPTS, 36'd2);
      send(CMD_RUN);
      send(CMD_READ, 0, 0, 0, 10'd3);
      wait_idle();
      write_csr(REG_EPS, 36'd0);
      write_csr(REG_MINPTS, 36'd1024);
      send(CMD_RUN);
      send(CMD_READ, 0, 0, 0, 10'd1);
      send(CMD_CLEAR);
      send(CMD_READ, 0, 0, 0, 10'd0);
      wait_idle();

      random_items = 0;
      while (random_items < 500) begin
         sel = $urandom_range(0, 9);
         if (sel == 0) eps_choice = 0;
         else if (sel == 1) eps_choice = 36'hFFFFFFFFF;
         else if (sel < 5) eps_choice = 36'($urandom_range(1, 20000));
         else eps_choice = {4'(0), $urandom};
         write_csr(REG_EPS, eps_choice);
         sel = $urandom_range(0, 9);
         write_csr(REG_MINPTS, sel == 0 ? 36'd1024 : 36'($urandom_range(0, 5)));
         if (random_items > 420) quiet = 1;
         send(CMD_CLEAR);
         n = 0;
         while (n < 24) begin
            sel = $urandom_range(1, 8);
            load_blob(sel, $urandom_range(0, 1) ? 80 : 600);
            n += sel;
            if ($urandom_range(0, 3) == 0) begin
               send(CMD_LOAD, 16'($urandom), 16'($urandom), 16'($urandom));
               n++;
            end
         end
         send(CMD_RUN);
         for (int i = 0; i < n + 2; i++) send(CMD_READ, 0, 0, 0, 10'(i));
         for (int i = 0; i < 4; i++) send_random();
         send(CMD_RUN);
         send(CMD_READ, 0, 0, 0, 10'($urandom_range(0, 1023)));
         random_items += 2 * n + 10;
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_status.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule
